/* hw/rtl/sum8_frame_deframer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sum8 frame deframer
// Clocked concurrent assertion wrappers, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef SUM8_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define SUM8_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the rising clock edge, checked during reset too.
`define SFD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sum8 frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [7:0]  START_BYTE_RST  = 8'h7E;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_ERROR = 2'd1,
    OP_FRAME = 2'd2
  } op_e;

  // One queued operation: STORE writes data at idx, ERROR carries the status in
  // data, FRAME carries the command in data and the payload count in idx.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [7:0] idx;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/sum8_frame_deframer_unit.sv */
// Throughput: one input byte per cycle while the operation queue has room.
// An error or payload-free frame result passes the operation queue, then the output register.
// Payload frames emit each result by a store read, then an output register load.
// Reset: asynchronous, active low; clears parser, queue and emitter control state,
// and returns start_byte to 0x7E. The payload store needs no clearing pass.
// ----------------------------------------------------------------------------
// sum8_frame_deframer_unit
// Parses start/mode/length/command/payload/sum8 frames out of a byte stream
// and emits the command and payload of each good frame, or one error result.
// ----------------------------------------------------------------------------
module sum8_frame_deframer_unit
  #(
  parameter int unsigned MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: start_byte register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] rx_byte, [15:8] bytes_left
  input  logic        s_axis_tuser_i,   // [0] first_of_buffer
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] command_id, [15:8] payload_byte
  output logic [2:0]  m_axis_tuser_o,   // [1:0] status, [2] has_payload
  output logic        m_axis_tlast_o    // last
);
  import sfd_pkg::*;

  q_entry_t   push_entry;
  q_entry_t   head;
  q_status_t  q_status;
  logic       push;
  logic       pop;
  logic [1:0] status;
  logic [7:0] command;
  logic [7:0] payload;
  logic       has_payload;

  // Front end: classify each transaction and queue at most one operation for it.
  sfd_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .rx_byte_i    (s_axis_tdata_i[7:0]),
    .first_i      (s_axis_tuser_i),
    .left_i       (s_axis_tdata_i[15:8]),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Queue: decouple parsing from emission so a payload burst does not stall input until the queue fills.
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // Back end: write payload bytes into the store, replay them when a frame checks out.
  sfd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (status),
    .command_o     (command),
    .payload_o     (payload),
    .has_payload_o (has_payload),
    .last_o        (m_axis_tlast_o)
  );

  // Pack result fields, highest first.
  assign m_axis_tdata_o = {payload, command};
  assign m_axis_tuser_o = {has_payload, status};

endmodule

/* hw/rtl/sfd_front.sv */
// ----------------------------------------------------------------------------
// sfd_front
// Byte parser: tracks frame phase and checksum, queues operations.
// ----------------------------------------------------------------------------
module sfd_front #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              first_i,
  input  logic [7:0]        left_i,
  input  sfd_pkg::q_status_t q_status_i,
  output logic              push_o,
  output sfd_pkg::q_entry_t push_entry_o
);
  import sfd_pkg::*;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_MODE  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_PAY   = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;

  localparam logic [8:0] LEN_MAX = 9'(MAX_PAYLOAD + 1);

  logic [7:0] start_q;
  logic [2:0] phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] cnt_q, cnt_d;
  logic       disc_q, disc_d;

  logic       acc;
  logic       at_end;
  logic       disc_eff;
  logic [2:0] ph_eff;
  logic [7:0] sum_add;
  logic [7:0] cnt_inc;

  assign in_ready_o = !q_status_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign at_end     = (left_i <= 8'd1);
  assign disc_eff   = first_i ? 1'b0 : disc_q;
  assign ph_eff     = first_i ? PH_START : phase_q;
  assign sum_add    = sum_q + rx_byte_i;
  assign cnt_inc    = cnt_q + 8'd1;

  always_comb begin
    phase_d      = phase_q;
    len_d        = len_q;
    cmd_d        = cmd_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    disc_d       = disc_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    if (acc) begin
      disc_d  = disc_eff;
      phase_d = ph_eff;
      if (!disc_eff) begin
        unique case (ph_eff)
          PH_START: begin
            if (left_i < 8'd4) begin
              disc_d = 1'b1;
            end else if (rx_byte_i != start_q) begin
              push_o            = 1'b1;
              push_entry_o.op   = OP_ERROR;
              push_entry_o.data = {6'd0, ST_BAD_START};
              disc_d            = 1'b1;
            end else begin
              sum_d   = rx_byte_i;
              phase_d = PH_MODE;
            end
          end
          PH_MODE: begin
            sum_d   = sum_add;
            phase_d = at_end ? PH_START : PH_LEN;
          end
          PH_LEN: begin
            if (rx_byte_i == 8'd0 || {1'b0, rx_byte_i} > LEN_MAX) begin
              push_o            = 1'b1;
              push_entry_o.op   = OP_ERROR;
              push_entry_o.data = {6'd0, ST_BAD_LEN};
              disc_d            = 1'b1;
              phase_d           = PH_START;
            end else begin
              sum_d   = sum_add;
              len_d   = rx_byte_i;
              phase_d = at_end ? PH_START : PH_CMD;
            end
          end
          PH_CMD: begin
            sum_d = sum_add;
            cmd_d = rx_byte_i;
            cnt_d = 8'd0;
            if (at_end) begin
              phase_d = PH_START;
            end else begin
              phase_d = (len_q == 8'd1) ? PH_SUM : PH_PAY;
            end
          end
          PH_PAY: begin
            push_o            = 1'b1;
            push_entry_o.op   = OP_STORE;
            push_entry_o.data = rx_byte_i;
            push_entry_o.idx  = cnt_q;
            cnt_d             = cnt_inc;
            sum_d             = sum_add;
            if (at_end) begin
              phase_d = PH_START;
            end else if (cnt_inc >= len_q - 8'd1) begin
              phase_d = PH_SUM;
            end
          end
          PH_SUM: begin
            phase_d = PH_START;
            push_o  = 1'b1;
            if (rx_byte_i != sum_q) begin
              push_entry_o.op   = OP_ERROR;
              push_entry_o.data = {6'd0, ST_BAD_SUM};
              disc_d            = 1'b1;
            end else begin
              push_entry_o.op   = OP_FRAME;
              push_entry_o.data = cmd_q;
              push_entry_o.idx  = len_q - 8'd1;
            end
          end
          default: begin
            phase_d = PH_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RST;
      phase_q <= PH_START;
      len_q   <= '0;
      cmd_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      disc_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      disc_q  <= disc_d;
    end
  end

endmodule

/* hw/rtl/sfd_queue.sv */
// ----------------------------------------------------------------------------
// sfd_queue
// Short operation queue between parser and emitter.
// ----------------------------------------------------------------------------
module sfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfd_pkg::q_entry_t  push_entry_i,
  input  logic               pop_i,
  output sfd_pkg::q_entry_t  head_o,
  output sfd_pkg::q_status_t status_o
);
  import sfd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (cnt_q == CW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hw/rtl/sfd_back.sv */
// ----------------------------------------------------------------------------
// sfd_back
// Emitter: owns the payload store and drives the registered result stream.
// ----------------------------------------------------------------------------
module sfd_back #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfd_pkg::q_entry_t  head_i,
  input  sfd_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         command_o,
  output logic [7:0]         payload_o,
  output logic               has_payload_o,
  output logic               last_o
);
  import sfd_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [7:0] store_q [MAX_PAYLOAD];
  logic [7:0] rd_q;

  logic [1:0] state_q, state_d;
  logic [7:0] k_q, k_d;
  logic [7:0] tot_q, tot_d;
  logic [7:0] cmdh_q, cmdh_d;
  logic       ov_q, ov_d;
  logic [1:0] st_q, st_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] pay_q, pay_d;
  logic       has_q, has_d;
  logic       last_q, last_d;
  logic       out_free;
  logic       wr_en;
  logic [7:0] k_inc;

  assign out_free = !ov_q || out_ready_i;
  assign pop_o    = (state_q == S_IDLE) && !q_status_i.empty &&
                    ((head_i.op == OP_STORE) || out_free);
  assign wr_en    = pop_o && (head_i.op == OP_STORE);
  assign k_inc    = k_q + 8'd1;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    tot_d   = tot_q;
    cmdh_d  = cmdh_q;
    ov_d    = ov_q && !out_ready_i;
    st_d    = st_q;
    cmd_d   = cmd_q;
    pay_d   = pay_q;
    has_d   = has_q;
    last_d  = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          unique case (head_i.op)
            OP_ERROR: begin
              ov_d   = 1'b1;
              st_d   = head_i.data[1:0];
              cmd_d  = 8'd0;
              pay_d  = 8'd0;
              has_d  = 1'b0;
              last_d = 1'b1;
            end
            OP_FRAME: begin
              if (head_i.idx == 8'd0) begin
                ov_d   = 1'b1;
                st_d   = ST_GOOD;
                cmd_d  = head_i.data;
                pay_d  = 8'd0;
                has_d  = 1'b0;
                last_d = 1'b1;
              end else begin
                tot_d   = head_i.idx;
                cmdh_d  = head_i.data;
                k_d     = 8'd0;
                state_d = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          ov_d   = 1'b1;
          st_d   = ST_GOOD;
          cmd_d  = cmdh_q;
          pay_d  = rd_q;
          has_d  = 1'b1;
          last_d = (k_inc == tot_q);
          if (k_inc == tot_q) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_inc;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[head_i.idx[AW-1:0]] <= head_i.data;
    end
    rd_q <= store_q[k_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    cmd_q  <= cmd_d;
    pay_q  <= pay_d;
    has_q  <= has_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      tot_q   <= '0;
      cmdh_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      tot_q   <= tot_d;
      cmdh_q  <= cmdh_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign command_o     = cmd_q;
  assign payload_o     = pay_q;
  assign has_payload_o = has_q;
  assign last_o        = last_q;

endmodule

/* hw/rtl/sfd_checker.sv */
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the deframer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "sum8_frame_deframer_unit_defines.svh"

module sfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Hold a stalled result unchanged.
  `SFD_ASSERT(a_out_hold, clk_i, rst_ni,
              m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
              $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
              $stable(m_axis_tlast_o), "stalled result changed")
  // Error results end the frame and carry neither command nor payload.
  `SFD_ASSERT(a_err_shape, clk_i, rst_ni,
              m_axis_tvalid_o && (m_axis_tuser_o[1:0] != 2'd0) |-> m_axis_tlast_o &&
              !m_axis_tuser_o[2] && (m_axis_tdata_o == 16'd0), "malformed error result")
  // A good result without payload is the single, final result of its frame.
  `SFD_ASSERT(a_nopay_last, clk_i, rst_ni,
              m_axis_tvalid_o && (m_axis_tuser_o[1:0] == 2'd0) && !m_axis_tuser_o[2] |->
              m_axis_tlast_o && (m_axis_tdata_o[15:8] == 8'd0), "payload-free result not last")
  // No result is offered once reset has been sampled low by the clock.
  `SFD_ASSERT_NR(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule

bind sum8_frame_deframer_unit sfd_checker u_sfd_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sum8 frame deframer. Builds received buffers of
// good, flawed, cut-off and fragmentary frames plus random noise, predicts the
// deframed results in step with accepted bytes and checks each result field.
// ----------------------------------------------------------------------------
module testbench;
  import sfd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 42;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PAY        = MAX_PAYLOAD_DEF;
  localparam int PAY_AW         = (MAX_PAY > 1) ? $clog2(MAX_PAY) : 1;

  typedef enum logic [2:0] {
    SEEK_START, TAKE_MODE, TAKE_LEN, TAKE_CMD, TAKE_PAYLOAD, TAKE_SUM
  } parse_phase_e;

  typedef enum int { FLAW_NONE, FLAW_START, FLAW_SUM, FLAW_LEN } frame_flaw_e;

  typedef struct {
    logic [7:0] rx;
    logic       first;
    logic [7:0] left;
  } byte_item_t;

  typedef struct {
    status_e    status;
    logic [7:0] cmd;
    logic [7:0] pay;
    logic       has_pay;
    logic       last;
  } deframe_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [7:0]  cfg_wdata_i     = 8'h00;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = 16'h0000;  // [7:0] rx_byte, [15:8] bytes_left
  logic        s_axis_tuser_i  = 1'b0;      // [0] first_of_buffer
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;              // [7:0] command_id, [15:8] payload_byte
  logic [2:0]  m_axis_tuser_o;              // [1:0] status, [2] has_payload
  logic        m_axis_tlast_o;              // last

  sum8_frame_deframer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Parser state mirrored from the block, plus its start byte setting.
  logic [7:0]      start_byte_cfg = START_BYTE_RST;
  parse_phase_e    parse_ph       = SEEK_START;
  logic [7:0]      frame_len      = 8'h00;
  logic [7:0]      cmd_hold       = 8'h00;
  logic [7:0]      run_sum        = 8'h00;
  logic [7:0]      pay_cnt        = 8'h00;
  logic [7:0]      pay_store [MAX_PAY];
  logic            drop_rest      = 1'b0;

  byte_item_t      rx_bytes_q[$];
  deframe_result_t deframed_q[$];
  logic [7:0]      frame_bytes[$];
  int              mismatch_cnt   = 0;
  int              idle_cycles    = 0;

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Deframing prediction
  // --------------------------------------------------------------------------
  task automatic flag_error(input status_e code);
    deframe_result_t r;
    r.status  = code;
    r.cmd     = 8'h00;
    r.pay     = 8'h00;
    r.has_pay = 1'b0;
    r.last    = 1'b1;
    deframed_q.push_back(r);
    drop_rest = 1'b1;
    parse_ph  = SEEK_START;
  endtask

  task automatic parse_byte(input logic [7:0] rx, input logic first, input logic [7:0] left);
    deframe_result_t r;
    logic            at_end;
    at_end = (left <= 8'd1);
    // a new buffer abandons any unfinished frame and lifts the discard
    if (first) begin
      drop_rest = 1'b0;
      parse_ph  = SEEK_START;
    end
    if (drop_rest) return;
    case (parse_ph)
      SEEK_START: begin
        // too few bytes left for a frame: drop the rest silently
        if (left < 8'd4) begin
          drop_rest = 1'b1;
          return;
        end
        if (rx != start_byte_cfg) begin
          flag_error(ST_BAD_START);
          return;
        end
        run_sum  = rx;
        parse_ph = TAKE_MODE;
        return;
      end
      TAKE_MODE: begin
        run_sum  = run_sum + rx;
        parse_ph = TAKE_LEN;
      end
      TAKE_LEN: begin
        // length is judged before any cut-off check
        if (rx == 8'd0 || int'(rx) > MAX_PAY + 1) begin
          flag_error(ST_BAD_LEN);
          return;
        end
        run_sum   = run_sum + rx;
        frame_len = rx;
        parse_ph  = TAKE_CMD;
      end
      TAKE_CMD: begin
        run_sum  = run_sum + rx;
        cmd_hold = rx;
        pay_cnt  = 8'd0;
        parse_ph = (frame_len == 8'd1) ? TAKE_SUM : TAKE_PAYLOAD;
      end
      TAKE_PAYLOAD: begin
        if (int'(pay_cnt) < MAX_PAY) pay_store[pay_cnt[PAY_AW-1:0]] = rx;
        pay_cnt = pay_cnt + 8'd1;
        run_sum = run_sum + rx;
        if (pay_cnt >= frame_len - 8'd1) parse_ph = TAKE_SUM;
      end
      TAKE_SUM: begin
        parse_ph = SEEK_START;
        if (rx != run_sum) begin
          flag_error(ST_BAD_SUM);
          return;
        end
        r.status = ST_GOOD;
        r.cmd    = cmd_hold;
        if (frame_len <= 8'd1) begin
          r.pay     = 8'h00;
          r.has_pay = 1'b0;
          r.last    = 1'b1;
          deframed_q.push_back(r);
        end else begin
          for (int k = 0; k + 1 < int'(frame_len) && k < MAX_PAY; k++) begin
            r.pay     = pay_store[PAY_AW'(k)];
            r.has_pay = 1'b1;
            r.last    = (k + 2 == int'(frame_len));
            deframed_q.push_back(r);
          end
        end
        return;
      end
      default: begin
        parse_ph = SEEK_START;
        return;
      end
    endcase
    // a frame that runs into the end of its buffer is dropped
    if (at_end) parse_ph = SEEK_START;
  endtask

  // --------------------------------------------------------------------------
  // Buffer construction
  // --------------------------------------------------------------------------
  task automatic add_frame(input logic [7:0] len, input frame_flaw_e flaw);
    logic [7:0] acc;
    logic [7:0] b;
    int         n_pay;
    b = (flaw == FLAW_START) ? start_byte_cfg ^ rand_byte(1, 255) : start_byte_cfg;
    frame_bytes.push_back(b);
    acc = b;
    b = rand_byte(0, 255);             // mode byte, never checked
    frame_bytes.push_back(b);
    acc = acc + b;
    frame_bytes.push_back(len);
    acc = acc + len;
    b = rand_byte(0, 255);             // command
    frame_bytes.push_back(b);
    acc = acc + b;
    n_pay = (flaw == FLAW_LEN) ? $urandom_range(0, 3) : int'(len) - 1;
    repeat (n_pay) begin
      b = rand_byte(0, 255);
      frame_bytes.push_back(b);
      acc = acc + b;
    end
    if (flaw == FLAW_SUM) acc = acc ^ rand_byte(1, 255);
    frame_bytes.push_back(acc);
  endtask

  // Hand the assembled bytes over as one buffer, counting bytes_left down to 1.
  task automatic send_buffer(input logic first_flag, output int n);
    byte_item_t  it;
    logic [31:0] rem;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      rem      = n - i;
      it.rx    = frame_bytes[i];
      it.first = first_flag && (i == 0);
      it.left  = rem[7:0];
      rx_bytes_q.push_back(it);
    end
    frame_bytes.delete();
  endtask

  task automatic push_noise(input int n);
    byte_item_t it;
    repeat (n) begin
      it.rx    = rand_byte(0, 255);
      it.first = ($urandom_range(0, 3) == 0);
      it.left  = rand_byte(1, 255);
      rx_bytes_q.push_back(it);
    end
  endtask

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'(MAX_PAY + 1);
    if (r < 15) return 8'(MAX_PAY);
    if (r < 25) return 8'd1;
    return rand_byte(2, 6);
  endfunction

  task automatic random_buffer(output int n);
    frame_flaw_e flaw;
    logic [7:0]  len;
    int          r;
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(0, 99);
      flaw = (r < 76) ? FLAW_NONE : (r < 84) ? FLAW_START : (r < 92) ? FLAW_SUM : FLAW_LEN;
      if (flaw == FLAW_LEN) len = $urandom_range(0, 1) ? 8'd0 : rand_byte(MAX_PAY + 2, 255);
      else len = pick_len();
      add_frame(len, flaw);
    end
    r = $urandom_range(0, 99);
    if (r < 15) begin
      // trailing fragment too short to hold a frame
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(rand_byte(0, 255));
    end else if (r < 30) begin
      // cut the last frame off at the buffer end
      repeat ($urandom_range(1, (frame_bytes.size() > 4) ? 4 : frame_bytes.size() - 1))
        frame_bytes.pop_back();
    end
    // now and then carry on after a finished buffer without a new-buffer mark
    send_buffer($urandom_range(0, 9) != 0, n);
  endtask

  task automatic fill_random(input int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 6));
      else begin
        random_buffer(n);
        sent += n;
      end
    end
  endtask

  task automatic push_directed();
    byte_item_t it;
    int         n;
    add_frame(8'd1, FLAW_NONE);              // good frame without payload
    send_buffer(1'b1, n);
    add_frame(8'd2, FLAW_SUM);               // bad sum, continuing the last buffer
    send_buffer(1'b0, n);
    it.rx    = 8'hFF;                        // bad start byte at the widest buffer
    it.first = 1'b1;
    it.left  = 8'd255;
    rx_bytes_q.push_back(it);
    add_frame(8'd0, FLAW_LEN);               // zero length
    send_buffer(1'b1, n);
    it.rx    = start_byte_cfg;               // start byte with only three bytes left
    it.first = 1'b1;
    it.left  = 8'd3;
    rx_bytes_q.push_back(it);
    add_frame(8'd3, FLAW_NONE);              // frame cut off in its payload
    repeat (2) frame_bytes.pop_back();
    send_buffer(1'b1, n);
  endtask

  // Wait for every byte to go in and every result to come out, then let the
  // block finish any frame that ends without a result.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (rx_bytes_q.size() != 0 || s_axis_tvalid_i || deframed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_start_byte(input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    start_byte_cfg  = value;
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: advance on each accepted transaction, predict as it goes in
  // --------------------------------------------------------------------------
  int tx_gap  = 0;
  int tx_calm = 0;

  always @(posedge clk_i) begin
    byte_item_t it;
    logic       taken;
    if (rst_ni) begin
      taken = s_axis_tvalid_i && s_axis_tready_o;
      if (taken) parse_byte(s_axis_tdata_i[7:0], s_axis_tuser_i, s_axis_tdata_i[15:8]);
      if (!s_axis_tvalid_i || taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          it = rx_bytes_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {it.left, it.rx};
          s_axis_tuser_i  <= it.first;
          if (tx_calm > 0) tx_calm--;
          else begin
            tx_gap = idle_len();
            if ($urandom_range(0, 31) == 0) tx_calm = 48;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted transaction, stall at random
  // --------------------------------------------------------------------------
  int rx_stall = 0;
  int rx_calm  = 0;

  task automatic check_result();
    deframe_result_t want;
    if (deframed_q.size() == 0) begin
      report_mismatch($sformatf("result with none pending: st %0d cmd %02h pay %02h",
                                m_axis_tuser_o[1:0], m_axis_tdata_o[7:0],
                                m_axis_tdata_o[15:8]));
      return;
    end
    want = deframed_q.pop_front();
    if (m_axis_tuser_o[1:0] !== want.status || m_axis_tdata_o[7:0] !== want.cmd ||
        m_axis_tdata_o[15:8] !== want.pay || m_axis_tuser_o[2] !== want.has_pay ||
        m_axis_tlast_o !== want.last)
      report_mismatch($sformatf(
        "st/cmd/pay/hp/last got %0d/%02h/%02h/%0b/%0b want %0d/%02h/%02h/%0b/%0b",
        m_axis_tuser_o[1:0], m_axis_tdata_o[7:0], m_axis_tdata_o[15:8],
        m_axis_tuser_o[2], m_axis_tlast_o,
        want.status, want.cmd, want.pay, want.has_pay, want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_result();
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (rx_calm > 0) rx_calm--;
        else begin
          rx_stall = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
          if ($urandom_range(0, 31) == 0) rx_calm = 48;
        end
      end
    end
  end

  // Hang detection: too long without any transaction on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles", $time, idle_cycles);
        $display("[sum8_frame_deframer_unit] ERROR");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed frames and random traffic at the reset start byte, then random traffic
  // under each further start byte setting
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] start_settings [4];
    start_settings[0] = 8'h00;
    start_settings[1] = 8'hFF;
    start_settings[2] = rand_byte(1, 254);
    start_settings[3] = START_BYTE_RST;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    push_directed();
    fill_random(PHASE_ITEMS);
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_start_byte(start_settings[p]);
      @(negedge clk_i);
      fill_random(PHASE_ITEMS);
    end
    wait_drained();
    if (mismatch_cnt == 0) $display("[sum8_frame_deframer_unit] OK");
    else $display("[sum8_frame_deframer_unit] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_queue.sv
hw/rtl/sfd_back.sv
hw/rtl/sum8_frame_deframer_unit.sv
hw/rtl/sfd_checker.sv
dv/testbench.sv
